// ===== design/vias_pkg.sv =====
// ----------------------------------------------------------------------------
// vias_pkg: shared types and constants for the video input switch
// Event kinds, modes, timer width and list helpers.
// ----------------------------------------------------------------------------
package vias_pkg;

    localparam int TIMER_BITS_DEF = 22;
    localparam int CFG_W = 22;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        EV_PLUG_IN = 3'd0,
        EV_PLUG_OUT = 3'd1,
        EV_SIG_OK = 3'd2,
        EV_SIG_BAD = 3'd3,
        EV_SET_MODE = 3'd4,
        EV_SET_INPUT = 3'd5,
        EV_TICK = 3'd6,
        EV_NONE = 3'd7
    } kind_t;

    localparam logic [1:0] MODE_FILO = 2'd0;
    localparam logic [1:0] MODE_PRIO = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;
    localparam logic [1:0] MODE_OVR = 2'd3;

    localparam logic [2:0] REG_PRIO_FIRST = 3'd0;
    localparam logic [2:0] REG_PRIO_SECOND = 3'd1;
    localparam logic [2:0] REG_PRIO_THIRD = 3'd2;
    localparam logic [2:0] REG_PLUG_IN_DLY = 3'd3;
    localparam logic [2:0] REG_PLUG_OUT_DLY = 3'd4;
    localparam logic [2:0] REG_LOSS_DLY = 3'd5;
    localparam logic [2:0] REG_OVR_LOSS_DLY = 3'd6;
    localparam logic [2:0] REG_MANUAL_PORT = 3'd7;

    // one classified event handed from front to back
    typedef struct packed {
        kind_t kind;
        logic [1:0] port;
        logic [1:0] mode_arg;
    } event_t;

    // one result word
    typedef struct packed {
        logic [1:0] selected_port;
        logic switched;
        logic [1:0] reported_mode;
        logic in_override;
    } result_t;

    // three-entry port list
    typedef struct packed {
        logic [2:0][1:0] e;
        logic [1:0] n;
    } plist_t;

    // a port register holding 3 reads as port 2
    function automatic logic [1:0] regport(input logic [1:0] v);
        return (v == 2'd3) ? 2'd2 : v;
    endfunction

    function automatic logic lfind_ok(input plist_t l, input logic [1:0] p);
        logic r;
        r = 1'b0;
        for (int i = 0; i < 3; i++)
            if (i < int'(l.n) && l.e[i] == p) r = 1'b1;
        return r;
    endfunction

    // index of p in list; 3 when absent
    function automatic logic [1:0] lfind_pos(input plist_t l, input logic [1:0] p);
        logic [1:0] r;
        r = 2'd3;
        for (int i = 2; i >= 0; i--)
            if (i < int'(l.n) && l.e[i] == p) r = 2'(i);
        return r;
    endfunction

    function automatic plist_t lremove(input plist_t l, input logic [1:0] p);
        plist_t r;
        logic [1:0] k;
        r = l;
        k = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            if (i < int'(l.n) && l.e[i] != p)
            begin
                r.e[k] = l.e[i];
                k = k + 2'd1;
            end
        end
        r.n = k;
        return r;
    endfunction

    function automatic plist_t lprepend(input plist_t l, input logic [1:0] p);
        plist_t r;
        r = l;
        if (r.n > 2'd2) r.n = 2'd2;
        if (r.n >= 2'd2) r.e[2] = l.e[1];
        if (r.n >= 2'd1) r.e[1] = l.e[0];
        r.e[0] = p;
        r.n = r.n + 2'd1;
        return r;
    endfunction

endpackage

// ===== design/vias_front.sv =====
// ----------------------------------------------------------------------------
// vias_front: event intake
// Accepts input words, marks those that change nothing as EV_NONE, queues all.
// ----------------------------------------------------------------------------
module vias_front (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  vias_pkg::event_t in_ev,
    output logic q_valid,
    input  logic q_ready,
    output vias_pkg::event_t q_ev
);
    import vias_pkg::*;

    localparam int DEPTH = 2;

    event_t mem_reg [DEPTH];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    event_t cls;
    logic push, pop;

    // classify: port 3 makes port events inert, unknown mode too
    always_comb
    begin
        cls = in_ev;
        unique case (in_ev.kind)
            EV_PLUG_IN, EV_PLUG_OUT, EV_SIG_OK, EV_SIG_BAD, EV_SET_INPUT:
                if (in_ev.port == 2'd3) cls.kind = EV_NONE;
            EV_SET_MODE:
                if (in_ev.mode_arg == MODE_OVR) cls.kind = EV_NONE;
            default: ;
        endcase
    end

    assign in_ready = (cnt_reg != 2'(DEPTH));
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_ev = mem_reg[rp_reg];

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(DEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'(DEPTH) && !pop |=> cnt_reg == 2'(DEPTH))
        else $error("queue count moved while full");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cnt_reg) == 2'd0 && $past(push) |-> q_valid)
        else $error("pushed word not visible");

endmodule

// ===== design/vias_back.sv =====
// ----------------------------------------------------------------------------
// vias_back: switch engine
// Holds lists, mode, port and timers; handles one event in two steps.
// ----------------------------------------------------------------------------
module vias_back #(
    parameter int TIMER_BITS = vias_pkg::TIMER_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  vias_pkg::event_t q_ev,
    input  logic cfg_we,
    input  logic [vias_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [vias_pkg::CFG_W-1:0] cfg_data,
    output logic out_valid,
    input  logic out_ready,
    output vias_pkg::result_t out_res
);
    import vias_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXP = 3'b010,
        ST_OUT = 3'b100
    } state_t;

    localparam logic [TIMER_BITS-1:0] T_ZERO = '0;
    localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);

    // configuration
    logic [1:0] prio_reg [3];
    logic [CFG_W-1:0] pin_dly_reg, pout_dly_reg, loss_dly_reg, ovr_dly_reg;
    logic [1:0] man_reg;

    state_t st_reg, st_next;
    plist_t run_reg, run_next, plg_reg, plg_next;
    logic [2:0] sok_reg, sok_next;
    logic [1:0] aport_reg, aport_next, amode_reg, amode_next;
    logic [1:0] smode_reg, smode_next, sport_reg, sport_next;
    logic tin_on_reg, tin_on_next, tout_on_reg, tout_on_next, tl_on_reg, tl_on_next;
    logic [TIMER_BITS-1:0] tin_reg, tin_next, tout_reg, tout_next, tl_reg, tl_next;
    logic sw_reg, sw_next;
    logic [2:0] exp_reg, exp_next;
    result_t res_reg, res_next;

    logic [TIMER_BITS-1:0] d_pin, d_pout, d_loss, d_ovr;
    assign d_pin = TIMER_BITS'(pin_dly_reg);
    assign d_pout = TIMER_BITS'(pout_dly_reg);
    assign d_loss = TIMER_BITS'(loss_dly_reg);
    assign d_ovr = TIMER_BITS'(ovr_dly_reg);

    assign q_ready = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign out_res = res_reg;

    // main event logic
    always_comb
    begin
        logic [1:0] p, top, pos, pf;
        logic [TIMER_BITS-1:0] d;
        plist_t nr;
        st_next = st_reg;
        run_next = run_reg; plg_next = plg_reg; sok_next = sok_reg;
        aport_next = aport_reg; amode_next = amode_reg;
        smode_next = smode_reg; sport_next = sport_reg;
        tin_on_next = tin_on_reg; tout_on_next = tout_on_reg; tl_on_next = tl_on_reg;
        tin_next = tin_reg; tout_next = tout_reg; tl_next = tl_reg;
        sw_next = sw_reg; exp_next = exp_reg; res_next = res_reg;
        p = q_ev.port;
        pf = regport(prio_reg[0]);
        top = 2'd0; pos = 2'd0; d = '0; nr = run_reg;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    sw_next = 1'b0;
                    exp_next = 3'b000;
                    st_next = ST_EXP;
                    unique case (q_ev.kind)
                        EV_PLUG_IN:
                        begin
                            if (!lfind_ok(run_reg, p))
                            begin
                                plg_next = lprepend(lremove(plg_reg, p), p);
                                if (amode_reg == MODE_FILO || amode_reg == MODE_PRIO)
                                begin
                                    if (amode_reg == MODE_FILO)
                                        nr = lprepend(run_reg, p);
                                    else
                                    begin
                                        nr.n = 2'd0;
                                        for (int i = 0; i < 3; i++)
                                            if (lfind_ok(plg_next, regport(prio_reg[i]))
                                                && !lfind_ok(nr, regport(prio_reg[i])))
                                            begin
                                                nr.e[nr.n] = regport(prio_reg[i]);
                                                nr.n = nr.n + 2'd1;
                                            end
                                    end
                                    run_next = nr;
                                    if (amode_reg == MODE_FILO || (nr.n != 2'd0 && nr.e[0] == p))
                                    begin
                                        if (d_pin != T_ZERO)
                                        begin
                                            tin_on_next = 1'b1; tin_next = d_pin;
                                        end
                                        else
                                        begin
                                            tin_on_next = 1'b0; tin_next = '0;
                                            aport_next = p; sw_next = 1'b1;
                                            if (d_loss != T_ZERO)
                                            begin
                                                tl_on_next = 1'b1; tl_next = d_loss;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        EV_PLUG_OUT:
                        begin
                            sok_next[p] = 1'b0;
                            plg_next = lremove(plg_reg, p);
                            if (run_reg.n != 2'd0)
                            begin
                                top = run_reg.e[0];
                                nr = lremove(run_reg, p);
                                run_next = nr;
                                if (amode_reg == MODE_FILO || amode_reg == MODE_PRIO)
                                begin
                                    if (top == p)
                                    begin
                                        if (nr.n != 2'd0)
                                        begin
                                            if (d_pout != T_ZERO)
                                            begin
                                                tout_on_next = 1'b1; tout_next = d_pout;
                                            end
                                            else
                                            begin
                                                aport_next = nr.e[0]; sw_next = 1'b1;
                                                if (d_loss != T_ZERO)
                                                begin
                                                    tl_on_next = 1'b1; tl_next = d_loss;
                                                end
                                            end
                                        end
                                        else
                                        begin
                                            aport_next = pf; sw_next = 1'b1;
                                        end
                                    end
                                end
                                else if (amode_reg == MODE_OVR && p == regport(man_reg))
                                begin
                                    amode_next = smode_reg;
                                    aport_next = sport_reg; sw_next = 1'b1;
                                    d = (smode_reg == MODE_OVR) ? d_ovr : d_loss;
                                    if (d != T_ZERO)
                                    begin
                                        tl_on_next = 1'b1; tl_next = d;
                                    end
                                end
                            end
                        end
                        EV_SIG_OK: sok_next[p] = 1'b1;
                        EV_SIG_BAD:
                        begin
                            if (p == aport_reg)
                            begin
                                d = (amode_reg == MODE_OVR) ? d_ovr : d_loss;
                                if (d != T_ZERO)
                                begin
                                    tl_on_next = 1'b1; tl_next = d;
                                end
                            end
                            sok_next[p] = 1'b0;
                        end
                        EV_SET_MODE:
                        begin
                            if (q_ev.mode_arg == MODE_FILO)
                            begin
                                if (amode_reg != MODE_FILO)
                                begin
                                    amode_next = MODE_FILO;
                                    run_next = plg_reg;
                                    if (plg_reg.n != 2'd0 && plg_reg.e[0] != aport_reg)
                                    begin
                                        aport_next = plg_reg.e[0]; sw_next = 1'b1;
                                        if (d_loss != T_ZERO)
                                        begin
                                            tl_on_next = 1'b1; tl_next = d_loss;
                                        end
                                    end
                                end
                            end
                            else if (q_ev.mode_arg == MODE_PRIO)
                            begin
                                amode_next = MODE_PRIO;
                                nr.n = 2'd0;
                                for (int i = 0; i < 3; i++)
                                    if (lfind_ok(plg_reg, regport(prio_reg[i]))
                                        && !lfind_ok(nr, regport(prio_reg[i])))
                                    begin
                                        nr.e[nr.n] = regport(prio_reg[i]);
                                        nr.n = nr.n + 2'd1;
                                    end
                                run_next = nr;
                                if (nr.n != 2'd0)
                                begin
                                    if (nr.e[0] != aport_reg)
                                    begin
                                        aport_next = nr.e[0]; sw_next = 1'b1;
                                        if (d_loss != T_ZERO)
                                        begin
                                            tl_on_next = 1'b1; tl_next = d_loss;
                                        end
                                    end
                                end
                                else
                                begin
                                    aport_next = pf; sw_next = 1'b1;
                                end
                            end
                            else
                            begin
                                amode_next = MODE_FIXED;
                                aport_next = regport(man_reg); sw_next = 1'b1;
                            end
                        end
                        EV_SET_INPUT:
                        begin
                            aport_next = p; sw_next = 1'b1;
                            if (amode_reg != MODE_FIXED)
                            begin
                                smode_next = amode_reg; sport_next = aport_reg;
                                amode_next = MODE_OVR;
                                if (d_ovr != T_ZERO)
                                begin
                                    tl_on_next = 1'b1; tl_next = d_ovr;
                                end
                            end
                        end
                        EV_TICK:
                        begin
                            // count down, flag expiries for the next step
                            if (tin_on_reg)
                            begin
                                tin_next = tin_reg - T_ONE;
                                if (tin_next == T_ZERO)
                                begin
                                    tin_on_next = 1'b0; exp_next[0] = 1'b1;
                                end
                            end
                            if (tout_on_reg)
                            begin
                                tout_next = tout_reg - T_ONE;
                                if (tout_next == T_ZERO)
                                begin
                                    tout_on_next = 1'b0; exp_next[1] = 1'b1;
                                end
                            end
                            if (tl_on_reg)
                            begin
                                tl_next = tl_reg - T_ONE;
                                if (tl_next == T_ZERO)
                                begin
                                    tl_on_next = 1'b0; exp_next[2] = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXP:
            begin
                // expiry handlers in order plug-in, plug-out, loss
                logic [1:0] ap, am;
                logic lon;
                ap = aport_reg; am = amode_reg; lon = tl_on_reg;
                for (int k = 0; k < 2; k++)
                    if (exp_reg[k] && run_reg.n != 2'd0)
                    begin
                        ap = run_reg.e[0]; sw_next = 1'b1;
                        // override keeps its own loss delay
                        d = (am == MODE_OVR) ? d_ovr : d_loss;
                        if (d != T_ZERO)
                        begin
                            lon = 1'b1; tl_next = d;
                        end
                    end
                if (exp_reg[2] && !lon && !sok_reg[ap])
                begin
                    if (am == MODE_FILO || am == MODE_PRIO)
                    begin
                        pos = lfind_pos(run_reg, ap);
                        if (pos != 2'd3)
                        begin
                            if (pos + 2'd1 >= run_reg.n)
                            begin
                                if (ap != pf)
                                begin
                                    ap = pf; sw_next = 1'b1;
                                end
                            end
                            else
                            begin
                                ap = run_reg.e[pos + 2'd1]; sw_next = 1'b1;
                                if (d_loss != T_ZERO)
                                begin
                                    lon = 1'b1; tl_next = d_loss;
                                end
                            end
                        end
                    end
                    else if (am == MODE_OVR)
                    begin
                        am = smode_reg;
                        ap = sport_reg; sw_next = 1'b1;
                        d = (smode_reg == MODE_OVR) ? d_ovr : d_loss;
                        if (d != T_ZERO)
                        begin
                            lon = 1'b1; tl_next = d;
                        end
                    end
                end
                aport_next = ap; amode_next = am; tl_on_next = lon;
                res_next.selected_port = ap;
                res_next.switched = sw_next;
                res_next.in_override = (am == MODE_OVR);
                res_next.reported_mode = (am == MODE_OVR)
                    ? ((smode_reg <= MODE_PRIO) ? smode_reg : MODE_OVR) : am;
                st_next = ST_OUT;
            end
            ST_OUT:
                if (out_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg[0] <= 2'd0; prio_reg[1] <= 2'd1; prio_reg[2] <= 2'd2;
            pin_dly_reg <= '0; pout_dly_reg <= '0;
            loss_dly_reg <= CFG_W'(10000); ovr_dly_reg <= CFG_W'(10000);
            man_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_PRIO_FIRST: prio_reg[0] <= cfg_data[1:0];
                REG_PRIO_SECOND: prio_reg[1] <= cfg_data[1:0];
                REG_PRIO_THIRD: prio_reg[2] <= cfg_data[1:0];
                REG_PLUG_IN_DLY: pin_dly_reg <= cfg_data;
                REG_PLUG_OUT_DLY: pout_dly_reg <= cfg_data;
                REG_LOSS_DLY: loss_dly_reg <= cfg_data;
                REG_OVR_LOSS_DLY: ovr_dly_reg <= cfg_data;
                REG_MANUAL_PORT: man_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            run_reg <= '0; plg_reg <= '0; sok_reg <= '0;
            aport_reg <= 2'd0; amode_reg <= MODE_FILO;
            smode_reg <= MODE_FILO; sport_reg <= 2'd0;
            tin_on_reg <= 1'b0; tout_on_reg <= 1'b0; tl_on_reg <= 1'b0;
            tin_reg <= '0; tout_reg <= '0; tl_reg <= '0;
            sw_reg <= 1'b0; exp_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            run_reg <= run_next; plg_reg <= plg_next; sok_reg <= sok_next;
            aport_reg <= aport_next; amode_reg <= amode_next;
            smode_reg <= smode_next; sport_reg <= sport_next;
            tin_on_reg <= tin_on_next; tout_on_reg <= tout_on_next;
            tl_on_reg <= tl_on_next;
            tin_reg <= tin_next; tout_reg <= tout_next; tl_reg <= tl_next;
            sw_reg <= sw_next; exp_reg <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(st_reg)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_reg))
        else $error("result dropped before taken");
    a_lists: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg.n <= 2'd3 && plg_reg.n <= 2'd3) else $error("list overflow");
    a_ovr_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> res_reg.in_override == (amode_reg == MODE_OVR))
        else $error("override flag mismatch");

endmodule

// ===== design/video_input_auto_switch.sv =====
// Path: an accepted word passes the intake queue, the event step and the
// timer-expiry step before its result shows; a stalled result holds until taken.
// The two-step switch engine takes a new event only once the last result is taken.
// Reset: rst_n asynchronous active low clears lists, timers, mode FILO, port 0,
// and loads register defaults.
// ----------------------------------------------------------------------------
// video_input_auto_switch: picks which of three video inputs drives the output
// Intake queue in front, switch engine behind.
// ----------------------------------------------------------------------------
module video_input_auto_switch #(
    parameter int TIMER_BITS = vias_pkg::TIMER_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [7:0] s_tdata,   // port[1:0], mode_arg[3:2], pad
    input  logic [2:0] s_tuser,   // kind[2:0]
    output logic m_tvalid,
    input  logic m_tready,
    output logic [7:0] m_tdata,   // selected_port[1:0], switched[2],
                                  // reported_mode[4:3], in_override[5], pad
    input  logic cfg_we,
    input  logic [vias_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [vias_pkg::CFG_W-1:0] cfg_data
);
    import vias_pkg::*;

    event_t in_ev, q_ev;
    result_t res;
    logic q_valid, q_ready;

    assign in_ev.kind = kind_t'(s_tuser);
    assign in_ev.port = s_tdata[1:0];
    assign in_ev.mode_arg = s_tdata[3:2];

    vias_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_ev(in_ev),
        .q_valid(q_valid), .q_ready(q_ready), .q_ev(q_ev)
    );

    vias_back #(.TIMER_BITS(TIMER_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_ev(q_ev),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {2'b00, res.in_override, res.reported_mode,
                      res.switched, res.selected_port};

endmodule
